FILE: sv/two_input_fuzzy_inference_assert.svh
// Assertion macros for the two-input fuzzy inference block.
// Expects clk and rst_n in the scope of the module that uses them.
`ifndef TWO_INPUT_FUZZY_INFERENCE_ASSERT_SVH
`define TWO_INPUT_FUZZY_INFERENCE_ASSERT_SVH

// property checked in the same cycle
`define TIFI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// consequence checked in the cycle after the trigger
`define TIFI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/tifi_pkg.sv
// Shared types, widths and register codes of the two-input fuzzy inference block.
// No dependencies.
package tifi_pkg;

  localparam int ADC_BITS_DEF = 10;
  localparam int BRK_W        = 12;
  localparam int LVL_W        = 8;
  localparam int MU_W         = 9;
  localparam logic [MU_W-1:0] MU_ONE = 9'd256;
  localparam int RDEN_W       = 12;
  localparam int RDVD_W       = 21;
  localparam int RQ_W         = 9;
  localparam int PROD_W       = 17;
  localparam int NUM_W        = 20;
  localparam int WSUM_W       = 12;
  localparam int ODVD_W       = 28;
  localparam int CRISP_W      = 16;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 12;
  localparam int DIV_BPS_RAMP = 3;
  localparam int DIV_BPS_OUT  = 4;

  localparam logic [BRK_W-1:0] LOW_BREAK_RST  = 12'd802;
  localparam logic [BRK_W-1:0] MID_BREAK_RST  = 12'd1203;
  localparam logic [BRK_W-1:0] HIGH_BREAK_RST = 12'd2042;
  localparam logic [LVL_W-1:0] DIM_RST        = 8'd1;
  localparam logic [LVL_W-1:0] NORMAL_RST     = 8'd128;
  localparam logic [LVL_W-1:0] BRIGHT_RST     = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOW_BREAK    = 3'd0,
    CFG_MID_BREAK    = 3'd1,
    CFG_HIGH_BREAK   = 3'd2,
    CFG_DIM_LEVEL    = 3'd3,
    CFG_NORMAL_LEVEL = 3'd4,
    CFG_BRIGHT_LEVEL = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [BRK_W-1:0] low_brk;
    logic [BRK_W-1:0] mid_brk;
    logic [BRK_W-1:0] high_brk;
    logic [LVL_W-1:0] dim_lvl;
    logic [LVL_W-1:0] normal_lvl;
    logic [LVL_W-1:0] bright_lvl;
  } cfg_t;

  // breakpoint compare results of one reading
  typedef struct packed {
    logic le_high;
    logic le_mid;
    logic le_low;
  } cmp_t;

  // ramp divisions of one reading: a is the falling side, b the rising side
  typedef struct packed {
    cmp_t              cmp;
    logic [RDVD_W-1:0] dvd_a;
    logic [RDVD_W-1:0] dvd_b;
    logic [RDEN_W-1:0] den;
  } fuzz_t;

endpackage

FILE: sv/two_input_fuzzy_inference.sv
// An input transfer reaches the output channel through the register stages below, in order.
// One item per cycle while out_tready is high; each stage holds its item while the next is full.
// Register stages: fuzzify (1), ramp dividers (3), rule stages (3), output divider (4).
// Reset (synchronous, active low) empties the pipeline and loads the default breakpoints/levels.
// Depends on tifi_pkg, tifi_fuzz, tifi_div, tifi_rule and two_input_fuzzy_inference_assert.svh.
`include "two_input_fuzzy_inference_assert.svh"
module two_input_fuzzy_inference
  import tifi_pkg::*;
#(
  parameter int ADC_BITS = ADC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // reading_one, reading_two, zero fill
  input  logic [((2*ADC_BITS+7)/8)*8-1:0]      in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // crisp_out
  output logic [CRISP_W-1:0]                   out_tdata,
  // zero_weight
  output logic                                 out_tuser,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [CFG_IDX_W-1:0]                 cfg_index,
  input  logic [CFG_DATA_W-1:0]                cfg_data
);

  cfg_t                 cfg_r;
  fuzz_t [1:0]          fz;
  logic                 fz_valid, fz_ready;
  logic [1:0][RQ_W-1:0] qa, qb;
  logic [5:0]           ramp_side;
  logic [5:0]           ramp_side_q;
  logic                 ramp_valid, ramp_ready;
  logic                 rule_valid, rule_ready;
  logic [ODVD_W-1:0]    rule_dvd;
  logic [WSUM_W-1:0]    rule_den;
  logic                 rule_zero;
  logic [CRISP_W-1:0]   div_q;
  logic                 div_zero;

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_brk    <= LOW_BREAK_RST;
      cfg_r.mid_brk    <= MID_BREAK_RST;
      cfg_r.high_brk   <= HIGH_BREAK_RST;
      cfg_r.dim_lvl    <= DIM_RST;
      cfg_r.normal_lvl <= NORMAL_RST;
      cfg_r.bright_lvl <= BRIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_LOW_BREAK:    cfg_r.low_brk    <= cfg_data;
        CFG_MID_BREAK:    cfg_r.mid_brk    <= cfg_data;
        CFG_HIGH_BREAK:   cfg_r.high_brk   <= cfg_data;
        CFG_DIM_LEVEL:    cfg_r.dim_lvl    <= cfg_data[LVL_W-1:0];
        CFG_NORMAL_LEVEL: cfg_r.normal_lvl <= cfg_data[LVL_W-1:0];
        CFG_BRIGHT_LEVEL: cfg_r.bright_lvl <= cfg_data[LVL_W-1:0];
        default: ;
      endcase
    end
  end

  // fuzzify front end
  tifi_fuzz #(.ADC_BITS(ADC_BITS)) u_fuzz (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .rd_one    (in_tdata[ADC_BITS-1:0]),
    .rd_two    (in_tdata[2*ADC_BITS-1:ADC_BITS]),
    .out_valid (fz_valid),
    .out_ready (fz_ready),
    .out_fz    (fz)
  );

  // four ramp dividers in lockstep; lane a of reading one carries the handshake
  assign ramp_side = {fz[1].cmp, fz[0].cmp};

  tifi_div #(.DVD_W(RDVD_W), .DEN_W(RDEN_W), .Q_W(RQ_W), .BPS(DIV_BPS_RAMP), .SB_W(6))
  u_div_a0 (
    .clk(clk), .rst_n(rst_n),
    .in_valid(fz_valid), .in_ready(fz_ready),
    .in_dvd(fz[0].dvd_a), .in_den(fz[0].den), .in_side(ramp_side),
    .out_valid(ramp_valid), .out_ready(ramp_ready),
    .out_q(qa[0]), .out_side(ramp_side_q)
  );

  tifi_div #(.DVD_W(RDVD_W), .DEN_W(RDEN_W), .Q_W(RQ_W), .BPS(DIV_BPS_RAMP), .SB_W(6))
  u_div_b0 (
    .clk(clk), .rst_n(rst_n),
    .in_valid(fz_valid), .in_ready(),
    .in_dvd(fz[0].dvd_b), .in_den(fz[0].den), .in_side(ramp_side),
    .out_valid(), .out_ready(ramp_ready),
    .out_q(qb[0]), .out_side()
  );

  tifi_div #(.DVD_W(RDVD_W), .DEN_W(RDEN_W), .Q_W(RQ_W), .BPS(DIV_BPS_RAMP), .SB_W(6))
  u_div_a1 (
    .clk(clk), .rst_n(rst_n),
    .in_valid(fz_valid), .in_ready(),
    .in_dvd(fz[1].dvd_a), .in_den(fz[1].den), .in_side(ramp_side),
    .out_valid(), .out_ready(ramp_ready),
    .out_q(qa[1]), .out_side()
  );

  tifi_div #(.DVD_W(RDVD_W), .DEN_W(RDEN_W), .Q_W(RQ_W), .BPS(DIV_BPS_RAMP), .SB_W(6))
  u_div_b1 (
    .clk(clk), .rst_n(rst_n),
    .in_valid(fz_valid), .in_ready(),
    .in_dvd(fz[1].dvd_b), .in_den(fz[1].den), .in_side(ramp_side),
    .out_valid(), .out_ready(ramp_ready),
    .out_q(qb[1]), .out_side()
  );

  // rule strengths and weighted sums
  tifi_rule u_rule (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (ramp_valid),
    .in_ready  (ramp_ready),
    .in_cmp    (ramp_side_q),
    .in_qa     (qa),
    .in_qb     (qb),
    .out_valid (rule_valid),
    .out_ready (rule_ready),
    .out_dvd   (rule_dvd),
    .out_den   (rule_den),
    .out_zero  (rule_zero)
  );

  // weighted average divider, its last stage is the output register
  tifi_div #(.DVD_W(ODVD_W), .DEN_W(WSUM_W), .Q_W(CRISP_W), .BPS(DIV_BPS_OUT), .SB_W(1))
  u_div_out (
    .clk(clk), .rst_n(rst_n),
    .in_valid(rule_valid), .in_ready(rule_ready),
    .in_dvd(rule_dvd), .in_den(rule_den), .in_side(rule_zero),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .out_q(div_q), .out_side(div_zero)
  );

  assign out_tdata = div_zero ? '0 : div_q;
  assign out_tuser = div_zero;

  `TIFI_ASSERT(a_zero_forces_out, (out_tvalid && out_tuser) |-> (out_tdata == '0), "zero weight with nonzero output")
  `TIFI_ASSERT(a_stall_source, (!in_tready) |-> (out_tvalid && !out_tready), "input stalled without output backpressure")
  `TIFI_ASSERT_NEXT(a_dim_write, (cfg_valid && cfg_ready && (cfg_index == CFG_DIM_LEVEL)), (cfg_r.dim_lvl == $past(cfg_data[LVL_W-1:0])), "dim level write lost")

endmodule

FILE: sv/tifi_div.sv
// Pipelined restoring divider, up to BPS quotient bits per stage, with sideband.
// Depends on tifi_pkg and two_input_fuzzy_inference_assert.svh.
`include "two_input_fuzzy_inference_assert.svh"
module tifi_div
  import tifi_pkg::*;
#(
  parameter int DVD_W = RDVD_W,
  parameter int DEN_W = RDEN_W,
  parameter int Q_W   = RQ_W,
  parameter int BPS   = DIV_BPS_RAMP,
  parameter int SB_W  = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [DVD_W-1:0] in_dvd,
  input  logic [DEN_W-1:0] in_den,
  input  logic [SB_W-1:0]  in_side,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [Q_W-1:0]   out_q,
  output logic [SB_W-1:0]  out_side
);

  localparam int CW  = DEN_W + Q_W;
  localparam int NST = (Q_W + BPS - 1) / BPS;

  logic [NST-1:0]   v_r;
  logic [CW-1:0]    rem_r   [NST];
  logic [Q_W-1:0]   q_r     [NST];
  logic [DEN_W-1:0] den_r   [NST];
  logic [SB_W-1:0]  sb_r    [NST];
  logic [CW-1:0]    rem_nxt [NST];
  logic [Q_W-1:0]   q_nxt   [NST];
  logic [NST-1:0]   v_in;
  logic [CW-1:0]    rem_in  [NST];
  logic [Q_W-1:0]   q_in    [NST];
  logic [DEN_W-1:0] den_in  [NST];
  logic [SB_W-1:0]  sb_in   [NST];
  logic [NST:0]     en;
  logic [CW-1:0]    last_den_ext;

  // a stage moves when it is empty or the next one moves
  assign en[NST] = out_ready;

  for (genvar s = 0; s < NST; s++) begin : g_stage
    assign en[s] = !v_r[s] || en[s+1];

    if (s == 0) begin : g_first
      assign v_in[s]   = in_valid;
      assign rem_in[s] = CW'(in_dvd);
      assign q_in[s]   = '0;
      assign den_in[s] = in_den;
      assign sb_in[s]  = in_side;
    end else begin : g_next
      assign v_in[s]   = v_r[s-1];
      assign rem_in[s] = rem_r[s-1];
      assign q_in[s]   = q_r[s-1];
      assign den_in[s] = den_r[s-1];
      assign sb_in[s]  = sb_r[s-1];
    end

    // quotient bits of this stage, most significant first
    always_comb begin
      logic [CW-1:0]  r;
      logic [CW-1:0]  sh;
      logic [Q_W-1:0] q;
      logic           ge;
      r = rem_in[s];
      q = q_in[s];
      for (int j = 0; j < BPS; j++) begin
        if (s * BPS + j < Q_W) begin
          sh = CW'(den_in[s]) << (Q_W - 1 - s * BPS - j);
          ge = (r >= sh);
          if (ge) begin
            r = r - sh;
          end
          q = {q[Q_W-2:0], ge};
        end
      end
      rem_nxt[s] = r;
      q_nxt[s]   = q;
    end

    // valid bit
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en[s]) begin
        v_r[s] <= v_in[s];
      end
    end

    // payload
    always_ff @(posedge clk) begin
      if (en[s]) begin
        rem_r[s] <= rem_nxt[s];
        q_r[s]   <= q_nxt[s];
        den_r[s] <= den_in[s];
        sb_r[s]  <= sb_in[s];
      end
    end
  end

  assign in_ready     = en[0];
  assign out_valid    = v_r[NST-1];
  assign out_q        = q_r[NST-1];
  assign out_side     = sb_r[NST-1];
  assign last_den_ext = CW'(den_r[NST-1]);

  `TIFI_ASSERT(a_rem_below_den, (v_r[NST-1] && (den_r[NST-1] != '0)) |-> (rem_r[NST-1] < last_den_ext), "divider remainder not below divisor")

endmodule

FILE: sv/tifi_fuzz.sv
// Input stage: scales readings, compares against breakpoints, forms ramp divisions.
// Depends on tifi_pkg.
module tifi_fuzz
  import tifi_pkg::*;
#(
  parameter int ADC_BITS = ADC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cfg_t                cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [ADC_BITS-1:0] rd_one,
  input  logic [ADC_BITS-1:0] rd_two,
  output logic                out_valid,
  input  logic                out_ready,
  output fuzz_t [1:0]         out_fz
);

  localparam int XW    = ADC_BITS + 2;
  localparam int CMP_W = (XW > BRK_W) ? XW : BRK_W;

  logic [XW-1:0] xs [2];
  fuzz_t [1:0]   fz_nxt;
  fuzz_t [1:0]   fz_r;
  logic          v_r;
  logic          en;

  assign xs[0] = {rd_one, 2'b00};
  assign xs[1] = {rd_two, 2'b00};

  // membership region and ramp operands per reading
  always_comb begin
    logic [CMP_W-1:0] xe, le, me, he;
    logic [BRK_W-1:0] na, nb, d;
    logic             used;
    cmp_t             c;
    le = CMP_W'(cfg.low_brk);
    me = CMP_W'(cfg.mid_brk);
    he = CMP_W'(cfg.high_brk);
    for (int i = 0; i < 2; i++) begin
      xe = CMP_W'(xs[i]);
      c.le_low  = (xe <= le);
      c.le_mid  = (xe <= me);
      c.le_high = (xe <= he);
      if (c.le_mid) begin
        na = BRK_W'(me - xe);
        nb = BRK_W'(xe - le);
        d  = cfg.mid_brk - cfg.low_brk;
      end else begin
        na = BRK_W'(he - xe);
        nb = BRK_W'(xe - me);
        d  = cfg.high_brk - cfg.mid_brk;
      end
      used = (c.le_mid && !c.le_low) || (!c.le_mid && c.le_high);
      fz_nxt[i].cmp   = c;
      fz_nxt[i].den   = d;
      fz_nxt[i].dvd_a = used ? ({1'b0, na, 8'b0} + RDVD_W'(d[BRK_W-1:1])) : '0;
      fz_nxt[i].dvd_b = used ? ({1'b0, nb, 8'b0} + RDVD_W'(d[BRK_W-1:1])) : '0;
    end
  end

  assign en = !v_r || out_ready;

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      fz_r <= fz_nxt;
    end
  end

  assign in_ready  = en;
  assign out_valid = v_r;
  assign out_fz    = fz_r;

endmodule

FILE: sv/tifi_rule.sv
// Rule stages: memberships, nine rule strengths, weighted sums, output dividend.
// Depends on tifi_pkg.
module tifi_rule
  import tifi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfg_t                  cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  cmp_t [1:0]            in_cmp,
  input  logic [1:0][RQ_W-1:0]  in_qa,
  input  logic [1:0][RQ_W-1:0]  in_qb,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ODVD_W-1:0]     out_dvd,
  output logic [WSUM_W-1:0]     out_den,
  output logic                  out_zero
);

  logic [2:0]               v_r;
  logic [3:0]               en;
  logic [8:0][MU_W-1:0]     w_nxt, w_r;
  logic [8:0][PROD_W-1:0]   prod_nxt, prod_r;
  logic [WSUM_W-1:0]        den_nxt, den_r, den2_r;
  logic [ODVD_W-1:0]        dvd_nxt, dvd_r;
  logic                     zero_r;
  logic [LVL_W-1:0]         lvl [3];

  assign lvl[0] = cfg.dim_lvl;
  assign lvl[1] = cfg.normal_lvl;
  assign lvl[2] = cfg.bright_lvl;

  // memberships and pairwise minimums
  always_comb begin
    logic [2:0][MU_W-1:0] mu [2];
    for (int i = 0; i < 2; i++) begin
      mu[i][0] = in_cmp[i].le_low ? MU_ONE : (in_cmp[i].le_mid ? in_qa[i] : '0);
      mu[i][1] = in_cmp[i].le_low ? '0 :
                 (in_cmp[i].le_mid ? in_qb[i] : (in_cmp[i].le_high ? in_qa[i] : '0));
      mu[i][2] = in_cmp[i].le_mid ? '0 : (in_cmp[i].le_high ? in_qb[i] : MU_ONE);
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        w_nxt[i*3+j] = (mu[0][i] <= mu[1][j]) ? mu[0][i] : mu[1][j];
      end
    end
  end

  // level products and total weight
  always_comb begin
    logic [WSUM_W-1:0] acc;
    acc = '0;
    for (int k = 0; k < 9; k++) begin
      prod_nxt[k] = PROD_W'(lvl[k % 3] * w_r[k]);
      acc = acc + WSUM_W'(w_r[k]);
    end
    den_nxt = acc;
  end

  // weighted sum and rounded dividend
  always_comb begin
    logic [NUM_W-1:0] num;
    num = '0;
    for (int k = 0; k < 9; k++) begin
      num = num + NUM_W'(prod_r[k]);
    end
    dvd_nxt = {num, 8'b0} + ODVD_W'(den_r[WSUM_W-1:1]);
  end

  // handshake chain
  assign en[3] = out_ready;
  for (genvar s = 0; s < 3; s++) begin : g_en
    assign en[s] = !v_r[s] || en[s+1];
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      if (en[1]) v_r[1] <= v_r[0];
      if (en[2]) v_r[2] <= v_r[1];
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en[0]) begin
      w_r <= w_nxt;
    end
    if (en[1]) begin
      prod_r <= prod_nxt;
      den_r  <= den_nxt;
    end
    if (en[2]) begin
      dvd_r  <= dvd_nxt;
      den2_r <= den_r;
      zero_r <= (den_r == '0);
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[2];
  assign out_dvd   = dvd_r;
  assign out_den   = den2_r;
  assign out_zero  = zero_r;

endmodule
